// ===== rtl/ordinal_date_to_month_day_weekday_core_defines.svh =====
// Assertion macros for the ordinal date converter.
`ifndef ORDINAL_DATE_TO_MONTH_DAY_WEEKDAY_CORE_DEFINES_SVH
`define ORDINAL_DATE_TO_MONTH_DAY_WEEKDAY_CORE_DEFINES_SVH

// Implication checked at every clock edge, off while in reset.
`define ODMDW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never hold, off while in reset.
`define ODMDW_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/odmdw_pkg.sv =====
// Constants and types shared by the ordinal date converter.
`default_nettype none

package odmdw_pkg;

	typedef logic [8:0] doy_t;

	// First day of each month minus one, common year
	localparam doy_t MONTH_START [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// y + 399 stands in for y - 1 within the 400-year cycle
	localparam int YEAR_OFFSET = 399;

	// floor(x / 400) = (x * RECIP_400) >> SHIFT_400, exact for x < 43690
	localparam int RECIP_400 = 20972;
	localparam int SHIFT_400 = 23;

	// floor(x / 7) = (x * RECIP_7) >> SHIFT_7, exact for x < 5461
	localparam int RECIP_7 = 4682;
	localparam int SHIFT_7 = 15;

	localparam int CYCLE_400 = 400;
	localparam int DAYS_WEEK = 7;
	localparam int LEN_COMMON = 365;
	localparam int LEN_LEAP = 366;

endpackage

`default_nettype wire

// ===== rtl/ordinal_date_to_month_day_weekday_core.sv =====
// Top level: Gregorian ordinal date to month, day of month and weekday.
// Structure: a five-stage pipeline from input transfer to result valid.
// Throughput: one transfer per cycle unless the output stalls; a stall holds a valid stage only while the next is held.
// Reset: arst_n clears all stage valid bits at once; data registers are not reset.
// The stage depth is set by the reciprocal multipliers for mod 400 and mod 7.
`default_nettype none
`include "ordinal_date_to_month_day_weekday_core_defines.svh"

module ordinal_date_to_month_day_weekday_core
	import odmdw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [13:0] year,
	input  wire logic [8:0]  day_of_year,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       month,
	output logic [4:0]       day_of_month,
	output logic [2:0]       weekday,
	output logic             range_error
);

	// Remainder by 100 of a value below 400: three compares
	function automatic logic [6:0] mod100(input logic [8:0] r);
		logic [8:0] t;
		begin
			if (r >= 9'd300) begin
				t = r - 9'd300;
			end else if (r >= 9'd200) begin
				t = r - 9'd200;
			end else if (r >= 9'd100) begin
				t = r - 9'd100;
			end else begin
				t = r;
			end
			return t[6:0];
		end
	endfunction

	// Stage advance chain: a stage moves when empty or when the next moves
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	assign adv5     = !v_s5 || out_ready;
	assign adv4     = !v_s4 || adv5;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	// Stage 1: offset year, reciprocal products for /400 of both years
	logic [14:0] a_in;
	logic [14:0] a_s1;
	logic [13:0] year_s1;
	doy_t        doy_s1;
	logic [29:0] pa_s1;
	logic [28:0] py_s1;

	assign a_in = 15'(year) + 15'(YEAR_OFFSET);

	always_ff @(posedge clk) begin
		if (adv1) begin
			a_s1    <= a_in;
			year_s1 <= year;
			doy_s1  <= day_of_year;
			pa_s1   <= 30'(a_in) * 30'(RECIP_400);
			py_s1   <= 29'(year) * 29'(RECIP_400);
		end
	end

	// Stage 2: remainders by 400
	logic [6:0]  qa;
	logic [5:0]  qy;
	logic [15:0] ra_full, ry_full;
	logic [8:0]  ra400_s2, ry400_s2;
	logic [1:0]  a4_s2, y4_s2;
	doy_t        doy_s2;

	assign qa      = pa_s1[29:SHIFT_400];
	assign qy      = py_s1[28:SHIFT_400];
	assign ra_full = 16'(a_s1) - 16'(qa) * 16'(CYCLE_400);
	assign ry_full = 16'(year_s1) - 16'(qy) * 16'(CYCLE_400);

	always_ff @(posedge clk) begin
		if (adv2) begin
			ra400_s2 <= ra_full[8:0];
			ry400_s2 <= ry_full[8:0];
			a4_s2    <= a_s1[1:0];
			y4_s2    <= year_s1[1:0];
			doy_s2   <= doy_s1;
		end
	end

	// Stage 3: leap year, range check, weekday sum before mod 7
	logic [6:0]  ra100, ry100;
	logic        leap;
	logic        err_c;
	logic [11:0] sum_c;
	logic [11:0] sum_s3;
	logic        leap_s3, err_s3;
	doy_t        doy_s3;

	assign ra100 = mod100(ra400_s2);
	assign ry100 = mod100(ry400_s2);
	// Divisible by 4, and not a century unless divisible by 400
	assign leap  = (y4_s2 == 2'd0) && !((ry100 == 7'd0) && (ry400_s2 != 9'd0));
	assign err_c = (doy_s2 == '0) ||
		(doy_s2 > (leap ? 9'(LEN_LEAP) : 9'(LEN_COMMON)));
	// 1 + 5(a%4) + 4(a%100) + 6(a%400) + (doy - 1)
	assign sum_c = 12'(a4_s2) * 12'd5 + 12'(ra100) * 12'd4 +
		12'(ra400_s2) * 12'd6 + 12'(doy_s2);

	always_ff @(posedge clk) begin
		if (adv3) begin
			sum_s3  <= sum_c;
			leap_s3 <= leap;
			err_s3  <= err_c;
			doy_s3  <= doy_s2;
		end
	end

	// Stage 4: reciprocal product for mod 7, month search on start table
	logic [3:0]  midx;
	doy_t        mstart;
	logic [11:0] sum_s4;
	logic [24:0] p7_s4;
	logic [3:0]  month_s4;
	doy_t        start_s4;
	logic        err_s4;
	doy_t        doy_s4;

	always_comb begin
		doy_t thr;
		midx   = '0;
		mstart = '0;
		for (int m = 1; m < 12; m++) begin
			thr = MONTH_START[m] + ((m >= 2 && leap_s3) ? 9'd1 : 9'd0);
			if (doy_s3 > thr) begin
				midx   = 4'(m);
				mstart = thr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			sum_s4   <= sum_s3;
			p7_s4    <= 25'(sum_s3) * 25'(RECIP_7);
			month_s4 <= midx + 4'd1;
			start_s4 <= mstart;
			err_s4   <= err_s3;
			doy_s4   <= doy_s3;
		end
	end

	// Stage 5: mod 7 remainder and day of month into the output register, zeroed fields on a range error
	logic [9:0]  q7;
	logic [11:0] wd_full;
	doy_t        md_full;

	assign q7      = p7_s4[24:SHIFT_7];
	assign wd_full = sum_s4 - 12'(q7) * 12'(DAYS_WEEK);
	assign md_full = doy_s4 - start_s4;

	always_ff @(posedge clk) begin
		if (adv5) begin
			range_error  <= err_s4;
			month        <= err_s4 ? 4'd0 : month_s4;
			day_of_month <= err_s4 ? 5'd0 : md_full[4:0];
			weekday      <= err_s4 ? 3'd0 : wd_full[2:0];
		end
	end

	assign out_valid = v_s5;

	`ODMDW_ASSERT(a_err_zero, (out_valid && range_error) |->
		(month == 4'd0 && day_of_month == 5'd0 && weekday == 3'd0),
		"error result with non-zero fields")
	`ODMDW_ASSERT(a_good_range, (out_valid && !range_error) |->
		(month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1 && weekday <= 3'd6),
		"good result out of range")
	`ODMDW_ASSERT(a_stall_hold, (v_s4 && !adv4) |=> (v_s4 && $stable(doy_s4)),
		"stalled stage lost its item")
	`ODMDW_NEVER(a_ready_full, in_ready && v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !out_ready,
		"input ready with full stalled pipeline")

endmodule

`default_nettype wire
